### hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, field widths and request/status codes for the positional
// array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam int CAPACITY_DEF = 64;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Request kinds
  localparam logic [KIND_W-1:0] K_INSERT   = 3'd0;
  localparam logic [KIND_W-1:0] K_DELETE   = 3'd1;
  localparam logic [KIND_W-1:0] K_RETRIEVE = 3'd2;
  localparam logic [KIND_W-1:0] K_LOCATE   = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell on an accepted transfer.
  typedef struct packed {
    logic              load;   // a transfer is accepted this cycle
    logic              ins;    // insert in range and list not full
    logic              del;    // delete in range
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } pal_cmd_t;

endpackage

### hw/rtl/positional_array_list.sv
// The cell row updates and registers its flags on the accept edge; in the scan
// state the result is registered from those flags once the output is free.
// A request is taken only in the idle state, so none is accepted until the
// previous one has left the scan state with its flags collected.
// A new request is taken while an earlier result still waits on the output.
// Reset (rst_n, synchronous, active low) empties the list; entry contents
// are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit values kept in a row of shifting cells, with
// insert, delete, retrieve, locate and clear requests.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [pal_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  logic [pal_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] read_value, [40:34] found_position, [47:41] length
  output logic [pal_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pal_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CW-1:0] CAP_X = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                loc_r, ret_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic [CW-1:0]     pos_x, cnt_x;
  logic              accept, ins_ok, del_ok, ret_ok, done;
  pal_cmd_t          cmd;

  logic [DATA_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0] match, sel;
  logic              any_match;
  logic [IDX_W-1:0]  first_idx;
  logic [DATA_W-1:0] rdata;
  logic [LEN_W-1:0]  found_v;
  logic [DATA_W-1:0] read_v;

  assign in_pos = in_tdata[POS_W-1:0];
  assign in_val = in_tdata[POS_W+DATA_W-1:POS_W];
  assign pos_x  = CW'(in_pos);
  assign cnt_x  = CW'(cnt_r);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    ret_ok     = 1'b0;
    status_nxt = ST_OK;
    cnt_nxt    = cnt_r;
    case (in_tuser)
      K_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else if (cnt_x >= CAP_X) begin
          status_nxt = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      K_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          del_ok  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      K_RETRIEVE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          ret_ok = 1'b1;
        end
      end
      K_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign cmd.load  = accept;
  assign cmd.ins   = ins_ok;
  assign cmd.del   = del_ok;
  assign cmd.pos   = in_pos;
  assign cmd.value = in_val;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lo_d, hi_d;
    if (g == 0) begin : g_lo0
      assign lo_d = '0;
    end else begin : g_lo
      assign lo_d = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hiN
      assign hi_d = '0;
    end else begin : g_hi
      assign hi_d = ent[g+1];
    end
    pal_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .cnt     (cnt_r),
      .lo_data (lo_d),
      .hi_data (hi_d),
      .data    (ent[g]),
      .match   (match[g]),
      .sel     (sel[g])
    );
  end

  pal_collect #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_collect (
    .ent       (ent),
    .match     (match),
    .sel       (sel),
    .any_match (any_match),
    .first_idx (first_idx),
    .rdata     (rdata)
  );

  // Locate reports the length when nothing matches; count is unchanged by it.
  always_comb begin
    found_v = '0;
    if (loc_r) begin
      found_v = any_match ? LEN_W'(CW'(first_idx)) : LEN_W'(cnt_x);
    end
    read_v = ret_r ? rdata : '0;
  end

  assign done = (state_r == S_SCAN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      loc_r    <= (in_tuser == K_LOCATE);
      ret_r    <= ret_ok;
    end
    if (done) begin
      out_data_r <= {LEN_W'(cnt_x), found_v, read_v, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cnt_r) <= CAP_X)
    else $error("list length exceeds capacity");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN))
    else $error("accepted transfer did not start collection");

  a_scan_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && !out_valid_r |=> out_valid_r)
    else $error("result not presented after collection");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("length changed without a transfer");
`endif

endmodule

### hw/rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list entry. Shifts up or down with its neighbors, takes the inserted
// value at its own position and flags matches for locate and retrieve.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                      clk,
  input  pal_pkg::pal_cmd_t         cmd,
  input  logic [CNT_W-1:0]          cnt,
  input  logic [pal_pkg::DATA_W-1:0] lo_data,
  input  logic [pal_pkg::DATA_W-1:0] hi_data,
  output logic [pal_pkg::DATA_W-1:0] data,
  output logic                      match,
  output logic                      sel
);
  import pal_pkg::*;

  localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r, sel_r;
  logic [CW-1:0]     pos_x, cnt_x;

  assign pos_x = CW'(cmd.pos);
  assign cnt_x = CW'(cnt);

  always_comb begin
    data_nxt = data_r;
    if (cmd.load && cmd.ins) begin
      if (IDX_V > pos_x) begin
        data_nxt = lo_data;
      end else if (IDX_V == pos_x) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.load && cmd.del) begin
      if (IDX_V >= pos_x) begin
        data_nxt = hi_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.load) begin
      // Flags are taken against the entry before this transfer; locate and
      // retrieve never modify the list, so they see the same contents.
      match_r <= (data_r == cmd.value) && (IDX_V < cnt_x);
      sel_r   <= (IDX_V == pos_x);
    end
  end

  assign data  = data_r;
  assign match = match_r;
  assign sel   = sel_r;

endmodule

### hw/rtl/pal_collect.sv
// ----------------------------------------------------------------------------
// pal_collect
// Gathers the cell flags: first matching position for locate and the
// selected entry for retrieve.
// ----------------------------------------------------------------------------
module pal_collect #(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6
) (
  input  logic [pal_pkg::DATA_W-1:0] ent [CAPACITY],
  input  logic [CAPACITY-1:0]        match,
  input  logic [CAPACITY-1:0]        sel,
  output logic                       any_match,
  output logic [IDX_W-1:0]           first_idx,
  output logic [pal_pkg::DATA_W-1:0] rdata
);
  import pal_pkg::*;

  // Walk from the top so the lowest matching cell wins.
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign any_match = |match;

  always_comb begin
    rdata = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rdata = rdata | (ent[i] & {DATA_W{sel[i]}});
    end
  end

endmodule

### bench/pal_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_result_checker
// Watches the request and result streams of the positional array list, keeps
// its own copy of the list contents and length, and compares every result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pal_result_checker #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [pal_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  logic [pal_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] read_value, [40:34] found_position, [47:41] length
  input  logic [pal_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatch_count,
  output int                              pending_results,
  output int                              checked_count,
  output int                              full_count,
  output int                              range_count,
  output int                              locate_hits
);
  import pal_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic [POS_W-1:0]    found_position;
    logic [LEN_W-1:0]    length;
  } list_result_t;

  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int                shadow_len;
  list_result_t      expected_results [$];
  int                n_bad;
  int                n_checked;
  int                n_full;
  int                n_range;
  int                n_hits;
  int                n_pending;

  assign mismatch_count  = n_bad;
  assign pending_results = n_pending;
  assign checked_count   = n_checked;
  assign full_count      = n_full;
  assign range_count     = n_range;
  assign locate_hits     = n_hits;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_request(input logic [KIND_W-1:0] kind,
                                                      input logic [POS_W-1:0]  pos,
                                                      input logic [DATA_W-1:0] value);
    list_result_t r;
    int           p;
    int           hit;
    r   = '0;
    p   = int'(pos);
    hit = -1;
    case (kind)
      K_INSERT: begin
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = value;
          shadow_len++;
        end
      end
      K_DELETE: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end
      end
      K_RETRIEVE: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_entries[p];
      end
      K_LOCATE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_entries[i] == value) hit = i;
        end
        r.found_position = (hit < 0) ? POS_W'(shadow_len) : POS_W'(hit);
      end
      K_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    list_result_t pred;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
      n_bad     = 0;
      n_checked = 0;
      n_full    = 0;
      n_range   = 0;
      n_hits    = 0;
      n_pending = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = apply_list_request(in_tuser, in_tdata[POS_W-1:0], in_tdata[POS_W +: DATA_W]);
        if (in_tuser == K_LOCATE && pred.found_position < pred.length) n_hits++;
        expected_results.push_back(pred);
      end
      if (out_tvalid && out_tready) begin
        got.status         = out_tdata[0 +: STATUS_W];
        got.read_value     = out_tdata[STATUS_W +: DATA_W];
        got.found_position = out_tdata[STATUS_W + DATA_W +: POS_W];
        got.length         = out_tdata[STATUS_W + DATA_W + POS_W +: LEN_W];
        if (expected_results.size() == 0) begin
          if (n_bad < 10)
            $display("unexpected result transfer at %0t: status=%0d length=%0d",
                     $realtime, got.status, got.length);
          n_bad++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_RANGE) n_range++;
          if (got !== want) begin
            if (n_bad < 10) begin
              $display("result %0d mismatch: expected status=%0d read=%0d found=%0d length=%0d",
                       n_checked, want.status, $signed(want.read_value),
                       want.found_position, want.length);
              $display("  got status=%0d read=%0d found=%0d length=%0d",
                       got.status, $signed(got.read_value), got.found_position,
                       got.length);
            end
            n_bad++;
          end
        end
      end
      n_pending = expected_results.size();
    end
  end

endmodule

### bench/positional_array_list_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_test
// Drives directed and random list requests into the positional array list
// with random gaps and result backpressure; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module positional_array_list_test;
  import pal_pkg::*;

  localparam int RANDOM_ITEMS = 1585;

  // Kind codes that the block must ignore.
  localparam logic [KIND_W-1:0] K_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] K_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] K_RSVD7 = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX, MODE_FILL} load_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatch_count;
  int pending_results;
  int checked_count;
  int full_count;
  int range_count;
  int locate_hits;

  logic tx_pause = 1'b1;
  logic rx_pause = 1'b1;
  logic rx_fired = 1'b0;
  int   rx_wait  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_array_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pal_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .checked_count   (checked_count),
    .full_count      (full_count),
    .range_count     (range_count),
    .locate_hits     (locate_hits)
  );

  // Result side: after each transfer, while paused, hold tready low for a random stretch.
  always @(posedge clk) rx_fired <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (rx_fired) begin
      if ($urandom_range(0, 39) == 0) rx_pause = !rx_pause;
      rx_wait = rx_pause ? $urandom_range(0, 12) : 0;
    end
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] value);
    int gap;
    gap = tx_pause ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, value, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input load_mode_t mode);
    int roll;
    int t_ins;
    int t_del;
    int t_ret;
    int t_loc;
    int t_clr;
    roll = $urandom_range(0, 199);
    case (mode)
      MODE_GROW:   begin t_ins = 120; t_del = 140; t_ret = 165; t_loc = 190; t_clr = 192; end
      MODE_SHRINK: begin t_ins = 30;  t_del = 120; t_ret = 150; t_loc = 185; t_clr = 188; end
      MODE_MIX:    begin t_ins = 60;  t_del = 110; t_ret = 145; t_loc = 185; t_clr = 190; end
      default:     begin t_ins = 200; t_del = 200; t_ret = 200; t_loc = 200; t_clr = 200; end
    endcase
    if (roll < t_ins) return K_INSERT;
    if (roll < t_del) return K_DELETE;
    if (roll < t_ret) return K_RETRIEVE;
    if (roll < t_loc) return K_LOCATE;
    if (roll < t_clr) return K_CLEAR;
    case ($urandom_range(0, 2))
      0:       return K_RSVD5;
      1:       return K_RSVD6;
      default: return K_RSVD7;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input load_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == MODE_FILL) return POS_W'($urandom_range(0, 2));
    if (roll < 55) return POS_W'($urandom_range(0, 8));
    if (roll < 88) return POS_W'($urandom_range(0, 66));
    return POS_W'($urandom_range(0, 127));
  endfunction

  // A small pool of values keeps locate hitting entries that are present.
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'h8000_0000;
    if (roll == 1) return 32'h7fff_ffff;
    if (roll == 2) return '0;
    if (roll == 3) return '1;
    if (roll < 12) return DATA_W'($urandom_range(0, 15) - 8);
    return $urandom;
  endfunction

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    load_mode_t mode;
    int         sent;
    int         phase_len;
    int         guard;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= K_INSERT;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Requests on the empty list, then a short list built from the extremes.
    send_request(K_RETRIEVE, 7'd0, '0);
    send_request(K_DELETE, 7'd0, '0);
    send_request(K_LOCATE, 7'd0, 32'd5);
    send_request(K_INSERT, 7'd1, 32'd9);
    send_request(K_INSERT, 7'd0, 32'h8000_0000);
    send_request(K_INSERT, 7'd1, 32'h7fff_ffff);
    send_request(K_INSERT, 7'd0, '0);
    send_request(K_INSERT, 7'd127, 32'd3);
    send_request(K_RETRIEVE, 7'd0, '0);
    send_request(K_RETRIEVE, 7'd2, '0);
    send_request(K_RETRIEVE, 7'd3, '0);
    send_request(K_RETRIEVE, 7'd127, '1);
    send_request(K_LOCATE, 7'd0, 32'h7fff_ffff);
    send_request(K_LOCATE, 7'd0, 32'd12345);
    send_request(K_LOCATE, 7'd127, '0);
    send_request(K_DELETE, 7'd1, '0);
    send_request(K_DELETE, 7'd2, '0);
    send_request(K_RSVD5, 7'd0, 32'd1);
    send_request(K_RSVD6, 7'd64, 32'h5555_5555);
    send_request(K_RSVD7, 7'd127, '1);
    send_request(K_CLEAR, 7'd127, '1);
    send_request(K_LOCATE, 7'd0, '0);
    send_request(K_RETRIEVE, 7'd0, '0);
    send_request(K_INSERT, 7'd0, '1);
    send_request(K_DELETE, 7'd0, '0);

    // Random phases; fill phases push the list to its capacity and beyond.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode = MODE_GROW;
        3, 4:    mode = MODE_SHRINK;
        5, 6, 7: mode = MODE_MIX;
        default: mode = MODE_FILL;
      endcase
      phase_len = (mode == MODE_FILL) ? $urandom_range(40, 70) : $urandom_range(40, 120);
      tx_pause  = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        send_request(pick_kind(mode), pick_pos(mode), pick_value());
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending_results != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    if (pending_results != 0) begin
      $display("Test completed with failures");
      $finish;
    end
    repeat (10) @(negedge clk);

    $display("Checked %0d results: %0d refused as full, %0d out of range, %0d locate hits.",
             checked_count, full_count, range_count, locate_hits);
    if (mismatch_count == 0 && pending_results == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### positional_array_list.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_collect.sv
hw/rtl/positional_array_list.sv
bench/pal_result_checker.sv
bench/positional_array_list_test.sv
